@@ src/smix_pkg.sv @@
`default_nettype none

package smix_pkg;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 17;

	localparam logic [CFG_INDEX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MUTE       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INPUT_GAIN = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FADER_GAIN = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_BALANCE    = 3'd4;

	// gain arithmetic: Q4.12 * Q4.12 -> Q8.24, balance factor Q1.15
	localparam int GAIN_W    = 16;
	localparam int BAL_W     = 17;
	localparam int G_W       = 2 * GAIN_W;
	localparam int SIDE_W    = 16;
	localparam int SIDE_FRAC = 15;
	localparam int E_W       = 32;
	localparam int GAIN_FRAC = 24;

	localparam int PEAK_W = 31;

	typedef logic [GAIN_W-1:0]        gain_t;
	typedef logic signed [BAL_W-1:0]  bal_t;
	typedef logic [PEAK_W-1:0]        peak_t;

	localparam gain_t GAIN_UNITY = 16'd4096;
	localparam logic signed [BAL_W:0] SIDE_UNITY = 18'sd32768;
	localparam logic [SIDE_W-1:0] SIDE_FULL = 16'h8000;
	localparam peak_t PEAK_MAX = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

@@ src/smix_ifs.sv @@
`default_nettype none

interface smix_in_if #(
	parameter int SAMPLE_BITS = 24,
	parameter int BUS_BITS    = 32
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] in_left;
	logic signed [SAMPLE_BITS-1:0] in_right;
	logic signed [BUS_BITS-1:0]    bus_left;
	logic signed [BUS_BITS-1:0]    bus_right;
	logic                          solo_muted;
	logic                          block_last;

	modport source (
		output valid, in_left, in_right, bus_left, bus_right, solo_muted, block_last,
		input  ready
	);
	modport sink (
		input  valid, in_left, in_right, bus_left, bus_right, solo_muted, block_last,
		output ready
	);
endinterface

interface smix_out_if import smix_pkg::*; #(
	parameter int BUS_BITS = 32
) ();
	logic                       valid;
	logic                       ready;
	logic signed [BUS_BITS-1:0] bus_left_out;
	logic signed [BUS_BITS-1:0] bus_right_out;
	peak_t                      peak_left;
	peak_t                      peak_right;
	logic                       peak_valid;
	logic                       clip_flag;

	modport source (
		output valid, bus_left_out, bus_right_out, peak_left, peak_right, peak_valid,
		output clip_flag,
		input  ready
	);
	modport sink (
		input  valid, bus_left_out, bus_right_out, peak_left, peak_right, peak_valid,
		input  clip_flag,
		output ready
	);
endinterface

`default_nettype wire

@@ src/stereo_channel_mix_and_peak_meter.sv @@
// Stereo mixer channel: input gain, fader gain and balance on a stereo
// sample pair, sum into the incoming mix bus pair, and a per-block peak meter.
// Channels: 'audio' carries one sample pair, the bus pair, solo_muted and
// block_last per beat; 'mix' returns one beat per input beat with the summed
// bus pair, the block peaks (nonzero only with peak_valid) and the sticky
// clip flag. Both are valid/ready; a beat moves when both are high.
// Settings are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce this.
// Throughput: one beat per cycle while 'mix' accepts. The input register, four
// pipeline stages (gain product, balance product, sample product, rounding) and
// the output register (sum/peak) each hold one beat; each multiplier has a stage
// of its own. When 'mix' stalls, the pipeline keeps accepting until its empty
// stages have filled, then ready drops; nothing is dropped or repeated.
// Reset: gains go to unity, balance to center, the channel is disabled and
// unmuted, running peaks and the clip flag clear, the pipeline empties.
`default_nettype none

module stereo_channel_mix_and_peak_meter
	import smix_pkg::*;
#(
	parameter int SAMPLE_BITS = 24,
	parameter int BUS_BITS    = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	smix_in_if.sink                     audio,
	smix_out_if.source                  mix
);

	localparam int PRODW = SAMPLE_BITS + E_W;
	localparam int MW    = PRODW - GAIN_FRAC;
	localparam int CW    = (MW > 32) ? MW : 33;
	localparam int CTW   = MW + 1;
	localparam int SUMW  = ((BUS_BITS > CTW) ? BUS_BITS : CTW) + 1;

	localparam logic [CW-1:0] CLIP_LEVEL = CW'(1) << (SAMPLE_BITS - 1);
	localparam logic [PRODW-1:0] ROUND_HALF = PRODW'(1) << (GAIN_FRAC - 1);

	// configuration registers
	logic  en_q, mute_q;
	gain_t in_gain_q, fader_gain_q;
	bal_t  bal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q         <= 1'b0;
			mute_q       <= 1'b0;
			in_gain_q    <= GAIN_UNITY;
			fader_gain_q <= GAIN_UNITY;
			bal_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:     en_q         <= cfg_wdata[0];
				REG_MUTE:       mute_q       <= cfg_wdata[0];
				REG_INPUT_GAIN: in_gain_q    <= cfg_wdata[GAIN_W-1:0];
				REG_FADER_GAIN: fader_gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_BALANCE:    bal_q        <= bal_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// pipeline valids and advance chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, out_v_q;
	logic ok1, ok2, ok3, ok4, ok5, ok_o;

	assign ok_o = !out_v_q || mix.ready;
	assign ok5  = !v_s5 || ok_o;
	assign ok4  = !v_s4 || ok5;
	assign ok3  = !v_s3 || ok4;
	assign ok2  = !v_s2 || ok3;
	assign ok1  = !v_s1 || ok2;
	assign audio.ready = ok1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (ok1)  v_s1    <= audio.valid;
			if (ok2)  v_s2    <= v_s1;
			if (ok3)  v_s3    <= v_s2;
			if (ok4)  v_s4    <= v_s3;
			if (ok5)  v_s5    <= v_s4;
			if (ok_o) out_v_q <= v_s5;
		end
	end

	// stage 1: input register
	logic signed [SAMPLE_BITS-1:0] l_s1, r_s1;
	logic signed [BUS_BITS-1:0]    bl_s1, br_s1;
	logic                          solo_s1, last_s1;

	always_ff @(posedge clk) begin
		if (ok1) begin
			l_s1    <= audio.in_left;
			r_s1    <= audio.in_right;
			bl_s1   <= audio.bus_left;
			br_s1   <= audio.bus_right;
			solo_s1 <= audio.solo_muted;
			last_s1 <= audio.block_last;
		end
	end

	// total gain, balance factors, sample magnitudes
	logic [G_W-1:0]             g_c;
	logic signed [BAL_W:0]      bal_ext, t_l, t_r;
	logic [SIDE_W-1:0]          side_l_c, side_r_c;
	logic [SAMPLE_BITS-1:0]     mag_l_c, mag_r_c;

	always_comb begin
		g_c      = G_W'(in_gain_q) * G_W'(fader_gain_q);
		bal_ext  = {bal_q[BAL_W-1], bal_q};
		t_r      = SIDE_UNITY + bal_ext;
		t_l      = SIDE_UNITY - bal_ext;
		side_l_c = SIDE_FULL;
		side_r_c = SIDE_FULL;
		if (bal_ext < 0) begin
			side_r_c = (t_r < 0) ? '0 : t_r[SIDE_W-1:0];
		end else if (bal_ext > 0) begin
			side_l_c = (t_l < 0) ? '0 : t_l[SIDE_W-1:0];
		end
		// magnitude of the most negative code wraps to the right unsigned value
		mag_l_c = l_s1[SAMPLE_BITS-1] ? (~l_s1 + SAMPLE_BITS'(1'b1)) : l_s1;
		mag_r_c = r_s1[SAMPLE_BITS-1] ? (~r_s1 + SAMPLE_BITS'(1'b1)) : r_s1;
	end

	// stage 2
	logic [G_W-1:0]             g_s2;
	logic [SIDE_W-1:0]          side_l_s2, side_r_s2;
	logic [SAMPLE_BITS-1:0]     mag_l_s2, mag_r_s2;
	logic                       neg_l_s2, neg_r_s2;
	logic signed [BUS_BITS-1:0] bl_s2, br_s2;
	logic                       solo_s2, last_s2;

	always_ff @(posedge clk) begin
		if (ok2) begin
			g_s2      <= g_c;
			side_l_s2 <= side_l_c;
			side_r_s2 <= side_r_c;
			mag_l_s2  <= mag_l_c;
			mag_r_s2  <= mag_r_c;
			neg_l_s2  <= l_s1[SAMPLE_BITS-1];
			neg_r_s2  <= r_s1[SAMPLE_BITS-1];
			bl_s2     <= bl_s1;
			br_s2     <= br_s1;
			solo_s2   <= solo_s1;
			last_s2   <= last_s1;
		end
	end

	// per-side gain: floor(g * side / 2^15)
	logic [G_W+SIDE_W-1:0] ge_l, ge_r;

	assign ge_l = (G_W+SIDE_W)'(g_s2) * (G_W+SIDE_W)'(side_l_s2);
	assign ge_r = (G_W+SIDE_W)'(g_s2) * (G_W+SIDE_W)'(side_r_s2);

	// stage 3
	logic [E_W-1:0]             e_l_s3, e_r_s3;
	logic [SAMPLE_BITS-1:0]     mag_l_s3, mag_r_s3;
	logic                       neg_l_s3, neg_r_s3;
	logic signed [BUS_BITS-1:0] bl_s3, br_s3;
	logic                       solo_s3, last_s3, gnz_s3;

	always_ff @(posedge clk) begin
		if (ok3) begin
			e_l_s3   <= ge_l[SIDE_FRAC +: E_W];
			e_r_s3   <= ge_r[SIDE_FRAC +: E_W];
			mag_l_s3 <= mag_l_s2;
			mag_r_s3 <= mag_r_s2;
			neg_l_s3 <= neg_l_s2;
			neg_r_s3 <= neg_r_s2;
			bl_s3    <= bl_s2;
			br_s3    <= br_s2;
			solo_s3  <= solo_s2;
			last_s3  <= last_s2;
			gnz_s3   <= (g_s2 != '0);
		end
	end

	// stage 4: sample times gain
	logic [PRODW-1:0]           prod_l_s4, prod_r_s4;
	logic                       neg_l_s4, neg_r_s4;
	logic signed [BUS_BITS-1:0] bl_s4, br_s4;
	logic                       solo_s4, last_s4, gnz_s4;

	always_ff @(posedge clk) begin
		if (ok4) begin
			prod_l_s4 <= PRODW'(mag_l_s3) * PRODW'(e_l_s3);
			prod_r_s4 <= PRODW'(mag_r_s3) * PRODW'(e_r_s3);
			neg_l_s4  <= neg_l_s3;
			neg_r_s4  <= neg_r_s3;
			bl_s4     <= bl_s3;
			br_s4     <= br_s3;
			solo_s4   <= solo_s3;
			last_s4   <= last_s3;
			gnz_s4    <= gnz_s3;
		end
	end

	// round half away from zero on the magnitude
	logic [PRODW-1:0] rnd_l, rnd_r;

	assign rnd_l = prod_l_s4 + ROUND_HALF;
	assign rnd_r = prod_r_s4 + ROUND_HALF;

	// stage 5
	logic [MW-1:0]              m_l_s5, m_r_s5;
	logic                       neg_l_s5, neg_r_s5;
	logic signed [BUS_BITS-1:0] bl_s5, br_s5;
	logic                       solo_s5, last_s5, gnz_s5;

	always_ff @(posedge clk) begin
		if (ok5) begin
			m_l_s5   <= rnd_l[PRODW-1:GAIN_FRAC];
			m_r_s5   <= rnd_r[PRODW-1:GAIN_FRAC];
			neg_l_s5 <= neg_l_s4;
			neg_r_s5 <= neg_r_s4;
			bl_s5    <= bl_s4;
			br_s5    <= br_s4;
			solo_s5  <= solo_s4;
			last_s5  <= last_s4;
			gnz_s5   <= gnz_s4;
		end
	end

	// bus sum with saturation, peak tracking
	peak_t run_l_q, run_r_q;
	logic  clip_q;

	logic [CW-1:0]              m_l_ext, m_r_ext;
	peak_t                      pk_l, pk_r, npk_l, npk_r, pub_l, pub_r;
	logic signed [CTW-1:0]      c_l, c_r;
	logic signed [SUMW-1:0]     sum_l, sum_r;
	logic signed [BUS_BITS-1:0] sat_l, sat_r, bus_l_c, bus_r_c;
	logic                       audible, clip_c, xfer_s5;

	localparam logic signed [BUS_BITS-1:0] BUS_MAX = {1'b0, {(BUS_BITS-1){1'b1}}};
	localparam logic signed [BUS_BITS-1:0] BUS_MIN = {1'b1, {(BUS_BITS-1){1'b0}}};

	always_comb begin
		m_l_ext = CW'(m_l_s5);
		m_r_ext = CW'(m_r_s5);
		pk_l    = (m_l_ext > CW'(PEAK_MAX)) ? PEAK_MAX : m_l_ext[PEAK_W-1:0];
		pk_r    = (m_r_ext > CW'(PEAK_MAX)) ? PEAK_MAX : m_r_ext[PEAK_W-1:0];
		npk_l   = '0;
		npk_r   = '0;
		if (en_q) begin
			npk_l = (pk_l > run_l_q) ? pk_l : run_l_q;
			npk_r = (pk_r > run_r_q) ? pk_r : run_r_q;
		end
		pub_l  = last_s5 ? npk_l : '0;
		pub_r  = last_s5 ? npk_r : '0;
		clip_c = clip_q || (last_s5 &&
			(CW'(npk_l) >= CLIP_LEVEL || CW'(npk_r) >= CLIP_LEVEL));

		c_l   = neg_l_s5 ? -$signed({1'b0, m_l_s5}) : $signed({1'b0, m_l_s5});
		c_r   = neg_r_s5 ? -$signed({1'b0, m_r_s5}) : $signed({1'b0, m_r_s5});
		sum_l = SUMW'(bl_s5) + SUMW'(c_l);
		sum_r = SUMW'(br_s5) + SUMW'(c_r);
		// overflow when the bits above the bus sign disagree
		if (&sum_l[SUMW-1:BUS_BITS-1] || ~|sum_l[SUMW-1:BUS_BITS-1]) begin
			sat_l = sum_l[BUS_BITS-1:0];
		end else begin
			sat_l = sum_l[SUMW-1] ? BUS_MIN : BUS_MAX;
		end
		if (&sum_r[SUMW-1:BUS_BITS-1] || ~|sum_r[SUMW-1:BUS_BITS-1]) begin
			sat_r = sum_r[BUS_BITS-1:0];
		end else begin
			sat_r = sum_r[SUMW-1] ? BUS_MIN : BUS_MAX;
		end
		audible = en_q && !mute_q && !solo_s5 && gnz_s5;
		bus_l_c = audible ? sat_l : bl_s5;
		bus_r_c = audible ? sat_r : br_s5;
	end

	assign xfer_s5 = v_s5 && ok_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_l_q <= '0;
			run_r_q <= '0;
			clip_q  <= 1'b0;
		end else if (xfer_s5) begin
			run_l_q <= last_s5 ? '0 : npk_l;
			run_r_q <= last_s5 ? '0 : npk_r;
			clip_q  <= clip_c;
		end
	end

	// output register
	logic signed [BUS_BITS-1:0] bus_l_q, bus_r_q;
	peak_t                      pub_l_q, pub_r_q;
	logic                       last_q, clip_out_q;

	always_ff @(posedge clk) begin
		if (ok_o) begin
			bus_l_q    <= bus_l_c;
			bus_r_q    <= bus_r_c;
			pub_l_q    <= pub_l;
			pub_r_q    <= pub_r;
			last_q     <= last_s5;
			clip_out_q <= clip_c;
		end
	end

	assign mix.valid         = out_v_q;
	assign mix.bus_left_out  = bus_l_q;
	assign mix.bus_right_out = bus_r_q;
	assign mix.peak_left     = pub_l_q;
	assign mix.peak_right    = pub_r_q;
	assign mix.peak_valid    = last_q;
	assign mix.clip_flag     = clip_out_q;

	// peaks read zero on beats that do not close a block
	peak_zero_off_block: assert property (@(posedge clk) disable iff (!arst_n)
		(mix.valid && !mix.peak_valid) |-> (mix.peak_left == '0 && mix.peak_right == '0))
		else $error("peak nonzero outside block end");

	clip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		clip_q |=> clip_q)
		else $error("clip flag cleared");

	block_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer_s5 && last_s5) |=> (run_l_q == '0 && run_r_q == '0))
		else $error("running peaks not cleared at block end");

	ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> audio.ready)
		else $error("input stage empty but not ready");

endmodule

`default_nettype wire
